/* hdl/bdq_pkg.sv */
package bdq_pkg;

    // Command codes as they arrive on the input stream
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_SCAN       = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNDERFLOW = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_EMPTY     = 2'd3
    } status_t;

    localparam int unsigned WORD_W = 32;

    // One classified command on its way from the front part to the back part
    typedef struct packed {
        op_t                       op;
        logic signed [WORD_W-1:0]  value;
    } cmd_t;

endpackage

/* hdl/bdq_front.sv */
module bdq_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [31:0]         s_axis_tdata,   // item_value[31:0]
    input  logic [2:0]          s_axis_tuser,   // cmd[2:0]
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output bdq_pkg::cmd_t       cmd
);
    import bdq_pkg::*;

    localparam int unsigned QDEPTH = 2;

    cmd_t        q_entry_reg [QDEPTH];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;
    logic        known_cmd;
    logic        push;
    logic        pop;
    cmd_t        in_cmd;

    // Classify: unused command codes are taken and dropped
    always_comb
    begin
        known_cmd    = s_axis_tuser inside {[OP_PUSH_FRONT:OP_POP_BACK]};
        in_cmd.op    = op_t'(s_axis_tuser);
        in_cmd.value = s_axis_tdata;
    end

    assign s_axis_tready = (fill_reg != 2'(QDEPTH));
    assign push          = s_axis_tvalid && s_axis_tready && known_cmd;
    assign cmd_valid     = (fill_reg != 2'd0);
    assign pop           = cmd_valid && cmd_ready;
    assign cmd           = q_entry_reg[rd_ptr_reg];

    // Advance queue pointers and fill level
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

/* hdl/bdq_back.sv */
module bdq_back
#(
    parameter int unsigned CAPACITY = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  bdq_pkg::cmd_t       cmd,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [31:0]         m_axis_tdata,   // out_value[31:0]
    output logic [1:0]          m_axis_tuser,   // status[1:0]
    output logic                m_axis_tlast    // last
);
    import bdq_pkg::*;

    localparam int unsigned IDX_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE     = 3'b001,
        ST_SCAN_RD  = 3'b010,
        ST_SCAN_OUT = 3'b100
    } state_t;

    logic signed [WORD_W-1:0]  store_mem [CAPACITY];
    logic signed [WORD_W-1:0]  rd_data_reg;

    state_t                    state_reg;
    state_t                    state_next;
    logic [IDX_W-1:0]          front_reg;
    logic [IDX_W-1:0]          front_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [IDX_W-1:0]          scan_idx_reg;
    logic [IDX_W-1:0]          scan_idx_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    status_t                   out_status_reg;
    status_t                   out_status_next;
    logic signed [WORD_W-1:0]  out_value_reg;
    logic signed [WORD_W-1:0]  out_value_next;
    logic                      out_last_reg;
    logic                      out_last_next;

    logic                      out_free;
    logic                      take_cmd;
    logic                      full;
    logic                      empty;
    logic [IDX_W-1:0]          front_dec;
    logic [IDX_W-1:0]          front_inc;
    logic [IDX_W:0]            tail_sum;
    logic [IDX_W-1:0]          tail_slot;
    logic [IDX_W:0]            scan_sum;
    logic [IDX_W-1:0]          scan_slot;
    logic                      scan_last;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign cmd_ready = (state_reg == ST_IDLE) && out_free;
    assign take_cmd  = cmd_valid && cmd_ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);

    // Slot arithmetic modulo CAPACITY: operands stay below CAPACITY
    always_comb
    begin
        front_dec = (front_reg == '0) ? IDX_W'(CAPACITY - 1) : front_reg - IDX_W'(1);
        front_inc = (front_reg == IDX_W'(CAPACITY - 1)) ? '0 : front_reg + IDX_W'(1);

        tail_sum  = {1'b0, front_reg} + {1'b0, count_reg[IDX_W-1:0]};
        tail_slot = (tail_sum >= (IDX_W+1)'(CAPACITY))
                    ? IDX_W'(tail_sum - (IDX_W+1)'(CAPACITY)) : tail_sum[IDX_W-1:0];

        scan_sum  = {1'b0, front_reg} + {1'b0, scan_idx_reg};
        scan_slot = (scan_sum >= (IDX_W+1)'(CAPACITY))
                    ? IDX_W'(scan_sum - (IDX_W+1)'(CAPACITY)) : scan_sum[IDX_W-1:0];

        scan_last = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == count_reg);
    end

    // Execute commands and step through scans
    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        wr_addr         = tail_slot;

        case (state_reg)
            ST_IDLE:
            begin
                if (take_cmd)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STATUS_OK;
                    out_value_next  = '0;
                    out_last_next   = 1'b1;
                    case (cmd.op)
                        OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                out_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                front_next = front_dec;
                                count_next = count_reg + CNT_W'(1);
                                wr_en      = 1'b1;
                                wr_addr    = front_dec;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                out_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                                wr_en      = 1'b1;
                                wr_addr    = tail_slot;
                            end
                        end
                        OP_SCAN:
                        begin
                            if (empty)
                            begin
                                out_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                // No result yet: first word comes from the read stage
                                out_valid_next = out_valid_reg && !m_axis_tready;
                                scan_idx_next  = '0;
                                state_next     = ST_SCAN_RD;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                out_status_next = STATUS_UNDERFLOW;
                            end
                            else
                            begin
                                front_next = front_inc;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                out_status_next = STATUS_UNDERFLOW;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            out_valid_next = out_valid_reg && !m_axis_tready;
                        end
                    endcase
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_OUT;
            end
            ST_SCAN_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STATUS_OK;
                    out_value_next  = rd_data_reg;
                    out_last_next   = scan_last;
                    if (scan_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                        state_next    = ST_SCAN_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    // Entry store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= cmd.value;
        end
        if (state_reg == ST_SCAN_RD)
        begin
            rd_data_reg <= store_mem[scan_slot];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

/* hdl/bounded_deque_with_scan.sv */
// Channel   Direction  tdata              tuser         tlast
// s_axis    in         item_value[31:0]   cmd[2:0]      -
// m_axis    out        out_value[31:0]    status[1:0]   last
//
// Push and pop complete in the back part's idle state; a scan moves each word
// through the registered read of the entry store, then the output register load,
// which waits on a stalled output. A two-entry command queue lets input transfers
// continue while the back part is busy or the output stalls. Reset clears the
// front slot, the count and all control state; no clearing pass is needed.
module bounded_deque_with_scan
#(
    parameter int unsigned CAPACITY = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // item_value[31:0]
    input  logic [2:0]   s_axis_tuser,   // cmd[2:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,   // out_value[31:0]
    output logic [1:0]   m_axis_tuser,   // status[1:0]
    output logic         m_axis_tlast    // last
);
    import bdq_pkg::*;

    logic  cmd_valid;
    logic  cmd_ready;
    cmd_t  cmd;

    // Accept, classify and queue commands
    bdq_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    // Execute commands against the circular store
    bdq_back #(
        .CAPACITY (CAPACITY)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
